// ----- rtl/core/sba_pkg.sv -----
// ----------------------------------------------------------------------------
// sba_pkg
// Shared constants, register indexes and the result type of the skyline
// block allocator.
// ----------------------------------------------------------------------------
package sba_pkg;

    // Default sizes of the column store and the row range.
    localparam int DEF_MAX_COLUMNS = 128;
    localparam int DEF_MAX_ROWS    = 1024;

    // Field widths of the stream items and the configuration registers.
    localparam int CMD_W      = 1;
    localparam int BW_W       = 8;
    localparam int BH_W       = 11;
    localparam int PW_W       = 8;
    localparam int PH_W       = 11;
    localparam int X_W        = 7;
    localparam int Y_W        = 10;
    localparam int IDX_W      = 16;
    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = 1;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 11;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_PAGE_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAGE_HEIGHT = 1'd1;

    // Register reset values.
    localparam logic [PW_W-1:0] PAGE_WIDTH_RST  = 8'd128;
    localparam logic [PH_W-1:0] PAGE_HEIGHT_RST = 11'd128;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ALLOC    = 1'b0;
    localparam logic [CMD_W-1:0] CMD_NEW_PAGE = 1'b1;

    typedef struct packed {
        logic             fits;
        logic [X_W-1:0]   place_x;
        logic [Y_W-1:0]   place_y;
        logic [IDX_W-1:0] page_index;
    } t_result;

endpackage

// ----- rtl/core/skyline_atlas_block_allocator_top.sv -----
// ----------------------------------------------------------------------------
// skyline_atlas_block_allocator_top
// Skyline rectangle packer for texture pages, with stream ports and a plain
// register write port.
// ----------------------------------------------------------------------------
// One item is in work at a time. The next item is taken after its result has
// passed to the output register, later while the output stalls. A rejected request
// goes straight to the result; a new page first clears the column store one entry
// per cycle; an allocate runs the forward and backward passes, then the column
// writes, which are skipped if the block does not fit.
// Synchronous active-low reset closes the page and empties the output register.
// ----------------------------------------------------------------------------
module skyline_atlas_block_allocator_top #(
    parameter int MAX_COLUMNS = sba_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = sba_pkg::DEF_MAX_ROWS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [7:0] block_width, [18:8] block_height, [23:19] zero
    input  logic [sba_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // [0] cmd
    input  logic [sba_pkg::S_TUSER_W-1:0]   i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [6:0] place_x, [16:7] place_y, [32:17] page_index, [39:33] zero
    output logic [sba_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // [0] fits
    output logic [sba_pkg::M_TUSER_W-1:0]   o_m_tuser,
    input  logic                            i_cfg_we,
    input  logic [sba_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [sba_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import sba_pkg::*;

    logic [PW_W-1:0] r_page_width;
    logic [PH_W-1:0] r_page_height;
    logic            r_out_valid;
    t_result         r_out;

    logic            seq_idle;
    logic            res_valid;
    logic            res_ready;
    t_result         res;
    logic            s_xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_width  <= PAGE_WIDTH_RST;
            r_page_height <= PAGE_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_PAGE_WIDTH:  r_page_width  <= i_cfg_wdata[PW_W-1:0];
                CFG_PAGE_HEIGHT: r_page_height <= i_cfg_wdata[PH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_xfer    = i_s_tvalid && seq_idle;
    assign res_ready = !r_out_valid || i_m_tready;

    sba_seq #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (s_xfer),
        .i_cmd          (i_s_tuser[0]),
        .i_block_width  (i_s_tdata[BW_W-1:0]),
        .i_block_height (i_s_tdata[BW_W+BH_W-1:BW_W]),
        .i_page_width   (r_page_width),
        .i_page_height  (r_page_height),
        .o_idle         (seq_idle),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (res)
    );

    // The output register lets a finished result wait while the next item
    // is taken in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_s_tready = seq_idle;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out.page_index, r_out.place_y, r_out.place_x};
    assign o_m_tuser  = r_out.fits;

endmodule

// ----- rtl/core/sba_ram.sv -----
// ----------------------------------------------------------------------------
// sba_ram
// Simple dual-port memory: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module sba_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 11,
    parameter int AW    = 7
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- rtl/core/sba_seq.sv -----
// ----------------------------------------------------------------------------
// sba_seq
// Sequencer and shared max/compare unit of the skyline allocator. Span tops
// come from block-aligned prefix maxima (forward pass) and suffix maxima
// (backward pass), so every start column is scored by one lookup in each table.
// ----------------------------------------------------------------------------
module sba_seq #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sba_pkg::CMD_W-1:0]  i_cmd,
    input  logic [sba_pkg::BW_W-1:0]   i_block_width,
    input  logic [sba_pkg::BH_W-1:0]   i_block_height,
    input  logic [sba_pkg::PW_W-1:0]   i_page_width,
    input  logic [sba_pkg::PH_W-1:0]   i_page_height,
    output logic                       o_idle,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output sba_pkg::t_result           o_res
);
    import sba_pkg::*;

    localparam int AW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CW  = $clog2(MAX_COLUMNS + 1);
    localparam int HW  = $clog2(MAX_ROWS + 1);
    localparam int PWX = (CW > PW_W) ? CW : PW_W;
    localparam int PHX = (HW > PH_W) ? HW : PH_W;
    localparam int SW  = ((HW > BH_W) ? HW : BH_W) + 1;
    localparam int IW  = CW + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CLR  = 3'd1;
    localparam logic [2:0] ST_FWD  = 3'd2;
    localparam logic [2:0] ST_BWD  = 3'd3;
    localparam logic [2:0] ST_CHK  = 3'd4;
    localparam logic [2:0] ST_WR   = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]       r_state;
    logic [AW-1:0]    r_i;
    logic [AW-1:0]    r_k;
    logic             r_run;
    logic [AW-1:0]    r_bwm1;
    logic [BH_W-1:0]  r_bh;
    logic [HW-1:0]    r_acc;
    logic [HW-1:0]    r_best;
    logic [AW-1:0]    r_bx;
    logic             r_found;
    logic             r_fits;
    logic [IDX_W-1:0] r_page_count;
    logic             r_page_open;
    logic             r_rd_v;
    logic [AW-1:0]    r_rd_idx;
    logic             r_rd_fresh;
    logic             r_rd_win;

    logic [PWX-1:0]   bw_ext;
    logic [PWX-1:0]   pw_ext;
    logic [PHX-1:0]   ph_ext;
    logic [CW-1:0]    cols_c;
    logic [HW-1:0]    rows_c;
    logic [AW-1:0]    last_col;
    logic             bw_bad;
    logic [IW-1:0]    i_plus;
    logic             win_issue;
    logic [AW-1:0]    pre_raddr;
    logic [HW-1:0]    col_rdata;
    logic [HW-1:0]    pre_rdata;
    logic [HW-1:0]    acc_nx;
    logic [HW-1:0]    win;
    logic             take;
    logic [SW-1:0]    sum;
    logic             fit_ok;
    logic             col_we;
    logic [HW-1:0]    col_wdata;
    logic             pre_we;

    // Page size clipped to the store and row range.
    always_comb begin
        bw_ext = PWX'(i_block_width);
        pw_ext = PWX'(i_page_width);
        ph_ext = PHX'(i_page_height);
        cols_c = (pw_ext > PWX'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS) : CW'(pw_ext);
        rows_c = (ph_ext > PHX'(MAX_ROWS)) ? HW'(MAX_ROWS) : HW'(ph_ext);
        last_col = AW'(cols_c - CW'(1));
        bw_bad = (bw_ext == '0) || (bw_ext > PWX'(cols_c));
    end

    // Issue side: a start column opens a window when it plus the width fits.
    always_comb begin
        i_plus    = IW'(r_i) + IW'(r_bwm1);
        win_issue = i_plus < IW'(cols_c);
        pre_raddr = i_plus[AW-1:0];
    end

    // Shared max/compare unit.
    always_comb begin
        acc_nx = r_rd_fresh ? col_rdata : ((col_rdata > r_acc) ? col_rdata : r_acc);
        win    = (acc_nx > pre_rdata) ? acc_nx : pre_rdata;
        // Scanning right to left, an equal top moves the choice to the left.
        take   = r_rd_win && (r_found ? (win <= r_best) : (win < rows_c));
        sum    = SW'(r_best) + SW'(r_bh);
        fit_ok = sum <= SW'(rows_c);
    end

    always_comb begin
        col_we    = (r_state == ST_CLR) || (r_state == ST_WR);
        col_wdata = (r_state == ST_CLR) ? '0 : r_acc;
        pre_we    = (r_state == ST_FWD) && r_rd_v;
    end

    sba_ram #(
        .DEPTH (MAX_COLUMNS),
        .WIDTH (HW),
        .AW    (AW)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (r_i),
        .i_wdata (col_wdata),
        .i_raddr (r_i),
        .o_rdata (col_rdata)
    );

    sba_ram #(
        .DEPTH (MAX_COLUMNS),
        .WIDTH (HW),
        .AW    (AW)
    ) u_pre_ram (
        .i_clk   (i_clk),
        .i_we    (pre_we),
        .i_waddr (r_rd_idx),
        .i_wdata (acc_nx),
        .i_raddr (pre_raddr),
        .o_rdata (pre_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_run        <= 1'b0;
            r_rd_v       <= 1'b0;
            r_found      <= 1'b0;
            r_page_count <= '0;
            r_page_open  <= 1'b0;
        end else begin
            r_rd_v <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_i     <= '0;
                        r_k     <= '0;
                        r_run   <= 1'b1;
                        r_found <= 1'b0;
                        r_best  <= '0;
                        r_bx    <= '0;
                        r_bwm1  <= AW'(bw_ext - PWX'(1));
                        r_bh    <= i_block_height;
                        if (i_cmd == CMD_NEW_PAGE) begin
                            r_page_count <= r_page_count + IDX_W'(1);
                            r_page_open  <= 1'b1;
                            r_fits       <= 1'b1;
                            r_state      <= ST_CLR;
                        end else if (!r_page_open || bw_bad) begin
                            r_fits  <= 1'b0;
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_FWD;
                        end
                    end
                end
                ST_CLR: begin
                    if (r_i == AW'(MAX_COLUMNS - 1)) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_i <= r_i + AW'(1);
                    end
                end
                ST_FWD: begin
                    if (r_run) begin
                        r_rd_v     <= 1'b1;
                        r_rd_idx   <= r_i;
                        r_rd_fresh <= (r_k == '0);
                        r_rd_win   <= 1'b0;
                        // The block position of the last column is kept for
                        // the backward pass.
                        if (r_i == last_col) begin
                            r_run <= 1'b0;
                        end else begin
                            r_i <= r_i + AW'(1);
                            r_k <= (r_k == r_bwm1) ? '0 : r_k + AW'(1);
                        end
                    end
                    if (r_rd_v) begin
                        r_acc <= acc_nx;
                    end
                    if (!r_run && !r_rd_v) begin
                        r_run   <= 1'b1;
                        r_i     <= last_col;
                        r_state <= ST_BWD;
                    end
                end
                ST_BWD: begin
                    if (r_run) begin
                        r_rd_v     <= 1'b1;
                        r_rd_idx   <= r_i;
                        r_rd_fresh <= (r_k == r_bwm1) || (r_i == last_col);
                        r_rd_win   <= win_issue;
                        r_k        <= (r_k == '0) ? r_bwm1 : r_k - AW'(1);
                        if (r_i == '0) begin
                            r_run <= 1'b0;
                        end else begin
                            r_i <= r_i - AW'(1);
                        end
                    end
                    if (r_rd_v) begin
                        r_acc <= acc_nx;
                        if (take) begin
                            r_best  <= win;
                            r_bx    <= r_rd_idx;
                            r_found <= 1'b1;
                        end
                    end
                    if (!r_run && !r_rd_v) begin
                        r_state <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    if (r_found && fit_ok) begin
                        r_acc   <= HW'(sum);
                        r_i     <= r_bx;
                        r_k     <= '0;
                        r_fits  <= 1'b1;
                        r_state <= ST_WR;
                    end else begin
                        r_best  <= '0;
                        r_bx    <= '0;
                        r_fits  <= 1'b0;
                        r_state <= ST_DONE;
                    end
                end
                ST_WR: begin
                    if (r_k == r_bwm1) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_i <= r_i + AW'(1);
                        r_k <= r_k + AW'(1);
                    end
                end
                ST_DONE: begin
                    if (i_res_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_idle           = (r_state == ST_IDLE);
        o_res_valid      = (r_state == ST_DONE);
        o_res.fits       = r_fits;
        o_res.place_x    = X_W'(r_bx);
        o_res.place_y    = Y_W'(r_best);
        o_res.page_index = r_page_open ? (r_page_count - IDX_W'(1)) : '0;
    end

endmodule

// ----- rtl/core/sba_checker.sv -----
// ----------------------------------------------------------------------------
// sba_checker
// Port-level checks of the skyline block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module sba_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [sba_pkg::M_TDATA_W-1:0]   o_m_tdata,
    input logic [sba_pkg::M_TUSER_W-1:0]   o_m_tuser
);

    // After every accepted item the block is busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while previous item still in work");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
        (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result changed");

    // A failed allocation reports position zero.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[16:0] == 17'd0))
        else $error("failed allocation with nonzero position");

    // After reset the block is ready and holds no result.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && o_s_tready))
        else $error("block not idle after reset");

endmodule

bind skyline_atlas_block_allocator_top sba_checker u_sba_checker (.*);

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// Skyline block allocator testbench
// Runs a short directed sequence, then ten phases of random page and block
// requests, each under its own page size. Results are predicted from a local
// copy of the column heights and checked one transfer at a time.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sba_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int NUM_PHASES  = 10;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [BW_W-1:0]  width;
        logic [BH_W-1:0]  height;
        bit               drain_first;
    } t_block_req;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata   = '0;
    logic [S_TUSER_W-1:0]  i_s_tuser   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic [M_TUSER_W-1:0]  o_m_tuser;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // Local copy of the allocator state.
    logic [BH_W-1:0]  column_height [DEF_MAX_COLUMNS];
    logic [IDX_W-1:0] pages_opened;
    bit               page_is_open;
    logic [PW_W-1:0]  page_cols_reg;
    logic [PH_W-1:0]  page_rows_reg;

    t_block_req request_q[$];
    t_result    placement_q[$];
    t_block_req on_bus;
    int         requests_sent  = 0;
    int         results_seen   = 0;
    int         mismatches     = 0;
    int         cycle_count    = 0;
    int         send_idle_pct  = 7;
    int         recv_idle_pct  = 73;

    skyline_atlas_block_allocator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Works out the placement for one request and updates the column heights.
    function automatic t_result place_block(t_block_req req);
        int      cols;
        int      rows;
        int      best;
        int      best_x;
        int      top;
        bit      found;
        bit      ok;
        t_result res;
        res    = '0;
        cols   = (page_cols_reg > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : int'(page_cols_reg);
        rows   = (page_rows_reg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(page_rows_reg);
        best   = rows;
        best_x = 0;
        found  = 1'b0;
        if (req.cmd == CMD_NEW_PAGE) begin
            foreach (column_height[k]) column_height[k] = '0;
            pages_opened = pages_opened + 16'd1;
            page_is_open = 1'b1;
            res.fits       = 1'b1;
            res.page_index = pages_opened - 16'd1;
            return res;
        end
        if (page_is_open) res.page_index = pages_opened - 16'd1;
        if (!page_is_open || req.width == 0 || int'(req.width) > cols) return res;
        for (int i = 0; i + int'(req.width) <= cols; i++) begin
            top = 0;
            ok  = 1'b1;
            for (int j = 0; j < int'(req.width); j++) begin
                if (int'(column_height[i + j]) >= best) begin
                    ok = 1'b0;
                    break;
                end
                if (int'(column_height[i + j]) > top) top = column_height[i + j];
            end
            // Only a strictly lower top replaces the current pick, so the
            // leftmost span wins a tie.
            if (ok) begin
                best   = top;
                best_x = i;
                found  = 1'b1;
            end
        end
        if (!found || best + int'(req.height) > rows) return res;
        for (int j = 0; j < int'(req.width); j++)
            column_height[best_x + j] = BH_W'(best + int'(req.height));
        res.fits    = 1'b1;
        res.place_x = X_W'(best_x);
        res.place_y = Y_W'(best);
        return res;
    endfunction

    // Sender side.
    always @(posedge i_clk) begin : drive
        t_block_req req;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            placement_q.push_back(place_block(on_bus));
            requests_sent++;
        end
        if (i_rst_n && (!i_s_tvalid || o_s_tready)) begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                (!request_q[0].drain_first || requests_sent == results_seen)) begin
                req        = request_q.pop_front();
                on_bus     = req;
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {{(S_TDATA_W - BW_W - BH_W){1'b0}}, req.height, req.width};
                i_s_tuser  <= req.cmd;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver side and checking.
    always @(posedge i_clk) begin : observe
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got.fits       = o_m_tuser[0];
                got.place_x    = o_m_tdata[X_W-1:0];
                got.place_y    = o_m_tdata[X_W+Y_W-1:X_W];
                got.page_index = o_m_tdata[X_W+Y_W+IDX_W-1:X_W+Y_W];
                results_seen <= results_seen + 1;
                if (placement_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: fits=%0d x=%0d y=%0d page=%0d",
                                 got.fits, got.place_x, got.place_y, got.page_index);
                end else begin
                    want = placement_q.pop_front();
                    if (got.fits !== want.fits || got.place_x !== want.place_x ||
                        got.place_y !== want.place_y || got.page_index !== want.page_index) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: expected fits=%0d x=%0d y=%0d page=%0d, %s",
                                     results_seen, want.fits, want.place_x, want.place_y,
                                     want.page_index, $sformatf("got fits=%0d x=%0d y=%0d page=%0d",
                                     got.fits, got.place_x, got.place_y, got.page_index));
                    end
                end
            end
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_req(input logic [CMD_W-1:0] cmd, input int unsigned width,
                            input int unsigned height, input bit drain_first);
        t_block_req req;
        req.cmd         = cmd;
        req.width       = BW_W'(width);
        req.height      = BH_W'(height);
        req.drain_first = drain_first;
        request_q.push_back(req);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int unsigned value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= CFG_DATA_W'(value);
        if (addr == CFG_PAGE_WIDTH) page_cols_reg = PW_W'(value);
        else page_rows_reg = PH_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Checked on the falling edge, when every register of the edge has settled.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (request_q.size() != 0 || i_s_tvalid || placement_q.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // Mostly packing runs with random block sizes, plus new-page commands and malformed requests.
    task automatic queue_phase(input int count, input bit open_first, input int page_pct);
        int cols;
        int rows;
        int pick;
        int w;
        int h;
        cols = (page_cols_reg > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : int'(page_cols_reg);
        rows = (page_rows_reg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(page_rows_reg);
        if (open_first) push_req(CMD_NEW_PAGE, 0, 0, 1'b0);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < page_pct) begin
                push_req(CMD_NEW_PAGE, $urandom_range(255), $urandom_range(2047),
                         $urandom_range(99) == 0);
            end else if (pick < page_pct + 10) begin
                push_req(CMD_ALLOC, $urandom_range(255), $urandom_range(2047),
                         $urandom_range(99) == 0);
            end else begin
                if (cols == 0) w = $urandom_range(8, 1);
                else if ($urandom_range(99) < 65) w = $urandom_range((cols < 4) ? 1 : cols / 4, 1);
                else w = $urandom_range(cols, 1);
                pick = $urandom_range(99);
                if (rows == 0) h = $urandom_range(3);
                else if (pick < 4) h = 0;
                else if (pick < 84) h = $urandom_range((rows < 6) ? 1 : rows / 6, 1);
                else h = $urandom_range(rows, 1);
                push_req(CMD_ALLOC, w, h, $urandom_range(99) == 0);
            end
        end
    endtask

    initial begin : sequencer
        int unsigned phase_cols [NUM_PHASES] = '{128, 16, 255, 1, 0, 40, 128, 2, 64, 37};
        int unsigned phase_rows [NUM_PHASES] = '{1024, 64, 2047, 1, 100, 0, 300, 2, 1023, 2000};
        bit          phase_open [NUM_PHASES] = '{1, 0, 0, 1, 0, 0, 1, 1, 1, 0};
        int          phase_pages[NUM_PHASES] = '{6, 0, 6, 8, 8, 8, 5, 8, 5, 5};
        int          phase_items[NUM_PHASES] = '{140, 100, 120, 100, 30, 30, 130, 100, 130, 130};

        foreach (column_height[k]) column_height[k] = '0;
        pages_opened  = '0;
        page_is_open  = 1'b0;
        page_cols_reg = PAGE_WIDTH_RST;
        page_rows_reg = PAGE_HEIGHT_RST;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sequence on the reset page size of 128 by 128.
        push_req(CMD_ALLOC, 1, 1, 1'b0);           // no page open yet
        push_req(CMD_NEW_PAGE, 255, 2047, 1'b0);   // command fields are ignored
        push_req(CMD_ALLOC, 0, 5, 1'b0);           // zero width
        push_req(CMD_ALLOC, 129, 3, 1'b0);         // wider than the page
        push_req(CMD_ALLOC, 255, 2047, 1'b0);
        push_req(CMD_ALLOC, 128, 0, 1'b0);         // zero height over the full page
        push_req(CMD_ALLOC, 1, 128, 1'b1);         // column 0 filled to the top
        push_req(CMD_ALLOC, 128, 1, 1'b0);         // no span below the page height
        push_req(CMD_ALLOC, 127, 129, 1'b0);       // too tall
        push_req(CMD_ALLOC, 127, 128, 1'b0);       // fills the rest exactly
        push_req(CMD_ALLOC, 1, 1, 1'b0);           // page is full
        push_req(CMD_NEW_PAGE, 0, 0, 1'b0);
        push_req(CMD_ALLOC, 64, 10, 1'b0);
        push_req(CMD_ALLOC, 64, 5, 1'b0);
        push_req(CMD_ALLOC, 1, 1, 1'b0);           // lowest span is on the right
        push_req(CMD_ALLOC, 65, 2, 1'b0);          // equal tops, leftmost wins
        push_req(CMD_ALLOC, 3, 0, 1'b0);
        push_req(CMD_ALLOC, 128, 100, 1'b1);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(CFG_PAGE_WIDTH, phase_cols[p]);
            write_reg(CFG_PAGE_HEIGHT, phase_rows[p]);
            if (p < 3) begin
                send_idle_pct = 7;
                recv_idle_pct = 73;
            end else if (p < 7) begin
                send_idle_pct = 73;
                recv_idle_pct = 7;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            queue_phase(phase_items[p], phase_open[p], phase_pages[p]);
            wait_idle();
        end

        repeat (20) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
